### rtl/core/wls_pkg.sv
// ----------------------------------------------------------------------------
// wls_pkg
// Shared types and constants of the windowed latency statistics core.
// ----------------------------------------------------------------------------
package wls_pkg;

   localparam int CHANNEL_COUNT_DEF = 8;
   localparam int WINDOW_DEPTH_DEF  = 1024;
   localparam int QUEUE_DEPTH       = 4;

   localparam logic [1:0] REQ_RECORD = 2'd0;
   localparam logic [1:0] REQ_QUERY  = 2'd1;
   localparam logic [1:0] REQ_CLEAR  = 2'd2;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [3:0]  stage_index;
      logic [31:0] sample_value;
   } wls_req_type;

   typedef struct packed {
      logic [10:0] sample_total;
      logic [31:0] min_latency;
      logic [31:0] max_latency;
      logic [31:0] mean_latency;
      logic [31:0] p99_latency;
   } wls_rsp_type;

   typedef enum logic [1:0] {
      OP_RECORD,
      OP_QUERY,
      OP_QUERY_ZERO,
      OP_CLEAR
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type  op;
      logic [3:0]  ch;
      logic [31:0] value;
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REC_UPD,
      ST_Q_SCAN,
      ST_Q_DECIDE,
      ST_Q_WAIT_DIV,
      ST_RESULT
   } eng_state_type;

endpackage

### rtl/core/windowed_latency_stats_core.sv
// ----------------------------------------------------------------------------
// windowed_latency_stats_core
// Per-channel sliding window latency statistics: count, min, max, mean, p99.
// ----------------------------------------------------------------------------
// Usage: request items enter on req_* (valid/ready): record stores a sample,
// query returns one rsp_* item, clear empties every channel. Unknown request
// codes and records into absent channels are taken and dropped.
// A four-entry command queue sits behind the request port, so req_ready only
// drops when the queue is full.
// Record: the engine reads the sample memory, then updates the ring.
// Query: the time is set by the rank search, which reads the sample memory
// once per window entry for each of 32 bisection steps; the mean divider
// runs alongside it. Empty or absent channel queries skip both and go
// straight to the result; clear finishes in the idle state.
// Reset clears all channel state at once; the sample memory is not cleared,
// since only written entries below the fill count are ever used.
// When rsp_ready is low the result waits in the output register and the
// queue keeps taking request items until it fills.
// ----------------------------------------------------------------------------
module windowed_latency_stats_core #(
   parameter int CHANNEL_COUNT = wls_pkg::CHANNEL_COUNT_DEF,
   parameter int WINDOW_DEPTH  = wls_pkg::WINDOW_DEPTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  wls_pkg::wls_req_type req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output wls_pkg::wls_rsp_type rsp_payload
);
   import wls_pkg::*;

   logic    push;
   cmd_type push_cmd;
   logic    queue_full;
   logic    pop;
   logic    pop_valid;
   cmd_type pop_cmd;

   wls_front #(
      .CHANNEL_COUNT (CHANNEL_COUNT)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .queue_full  (queue_full),
      .push        (push),
      .push_cmd    (push_cmd)
   );

   wls_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .full      (queue_full),
      .pop       (pop),
      .pop_valid (pop_valid),
      .pop_cmd   (pop_cmd)
   );

   wls_engine #(
      .CHANNEL_COUNT (CHANNEL_COUNT),
      .WINDOW_DEPTH  (WINDOW_DEPTH)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .cmd_valid   (pop_valid),
      .cmd         (pop_cmd),
      .cmd_pop     (pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

### rtl/core/wls_front.sv
// ----------------------------------------------------------------------------
// wls_front
// Accepts request items, classifies them and pushes commands into the queue.
// ----------------------------------------------------------------------------
module wls_front #(
   parameter int CHANNEL_COUNT = wls_pkg::CHANNEL_COUNT_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  wls_pkg::wls_req_type req_payload,
   input  logic                 queue_full,
   output logic                 push,
   output wls_pkg::cmd_type     push_cmd
);
   import wls_pkg::*;

   logic in_range;
   logic accept;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;
   assign in_range  = {1'b0, req_payload.stage_index} < 5'(CHANNEL_COUNT);

   always_comb begin
      push           = 1'b0;
      push_cmd.op    = OP_RECORD;
      push_cmd.ch    = req_payload.stage_index;
      push_cmd.value = req_payload.sample_value;
      case (req_payload.req_type)
         REQ_RECORD: begin
            // records into absent channels are dropped here
            push = accept && in_range;
         end
         REQ_QUERY: begin
            push        = accept;
            push_cmd.op = in_range ? OP_QUERY : OP_QUERY_ZERO;
         end
         REQ_CLEAR: begin
            push        = accept;
            push_cmd.op = OP_CLEAR;
         end
         default: begin
            push = 1'b0;
         end
      endcase
   end

   assert property (@(posedge clock) disable iff (reset)
      (push && push_cmd.op == OP_RECORD) |-> in_range)
      else $error("record command for absent channel");

endmodule

### rtl/core/wls_queue.sv
// ----------------------------------------------------------------------------
// wls_queue
// Short command queue between the front and the execution engine.
// ----------------------------------------------------------------------------
module wls_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  wls_pkg::cmd_type push_cmd,
   output logic             full,
   input  logic             pop,
   output logic             pop_valid,
   output wls_pkg::cmd_type pop_cmd
);
   import wls_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   cmd_type          slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]   count_ff, count_in;
   logic             do_push, do_pop;

   assign full      = count_ff == (PTR_W+1)'(QUEUE_DEPTH);
   assign pop_valid = count_ff != '0;
   assign pop_cmd   = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (PTR_W+1)'(do_push) - (PTR_W+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

### rtl/core/wls_divider.sv
// ----------------------------------------------------------------------------
// wls_divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wls_divider #(
   parameter int DVD_W = 43,
   parameter int DSR_W = 11
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DSR_W-1:0] divisor,
   output logic [DVD_W-1:0] quotient,
   output logic             done
);
   localparam int CNT_W = $clog2(DVD_W + 1);

   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [DSR_W:0]   rem_ff, rem_in;
   logic [DSR_W-1:0] dsr_ff;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DSR_W:0]   rem_sh;
   logic [DSR_W:0]   rem_sub;

   assign quotient = quo_ff;
   assign done     = done_ff;

   always_comb begin
      rem_sh  = {rem_ff[DSR_W-1:0], quo_ff[DVD_W-1]};
      rem_sub = rem_sh - {1'b0, dsr_ff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         cnt_in  = CNT_W'(DVD_W);
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         if (rem_sh >= {1'b0, dsr_ff}) begin
            rem_in = rem_sub;
            quo_in = {quo_ff[DVD_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            quo_in = {quo_ff[DVD_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      if (start) begin
         dsr_ff <= divisor;
      end
   end

endmodule

### rtl/core/wls_engine.sv
// ----------------------------------------------------------------------------
// wls_engine
// Executes commands: ring update on record, mean and rank search on query, clear of all channels.
// ----------------------------------------------------------------------------
module wls_engine #(
   parameter int CHANNEL_COUNT = wls_pkg::CHANNEL_COUNT_DEF,
   parameter int WINDOW_DEPTH  = wls_pkg::WINDOW_DEPTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 cmd_valid,
   input  wls_pkg::cmd_type     cmd,
   output logic                 cmd_pop,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output wls_pkg::wls_rsp_type rsp_payload
);
   import wls_pkg::*;

   localparam int WIN_W     = $clog2(WINDOW_DEPTH);
   localparam int FILL_W    = $clog2(WINDOW_DEPTH + 1);
   localparam int SUM_W     = 32 + FILL_W;
   localparam int CH_W      = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
   localparam int MEM_DEPTH = CHANNEL_COUNT * WINDOW_DEPTH;
   localparam int ADDR_W    = $clog2(MEM_DEPTH);
   localparam int PROD_W    = FILL_W + 13;
   // n / 100 as (n * 5243) >> 19, exact for the window sizes in range
   localparam int RECIP100  = 5243;
   localparam int RECIP_SH  = 19;

   // per-channel state
   logic [WIN_W-1:0]  wp_ff   [CHANNEL_COUNT];
   logic [FILL_W-1:0] fill_ff [CHANNEL_COUNT];
   logic [SUM_W-1:0]  sum_ff  [CHANNEL_COUNT];
   logic [31:0]       min_ff  [CHANNEL_COUNT];
   logic [31:0]       max_ff  [CHANNEL_COUNT];

   logic [31:0] mem [MEM_DEPTH];
   logic [31:0] rd_data_ff;

   eng_state_type state_ff, state_in;
   cmd_op_type    op_ff, op_in;
   logic [CH_W-1:0]   ch_ff, ch_in;
   logic [31:0]       val_ff, val_in;
   logic [FILL_W-1:0] n_ff, n_in;
   logic [FILL_W-1:0] rank_ff, rank_in;
   logic [FILL_W-1:0] scan_ff, scan_in;
   logic [FILL_W-1:0] cnt_ff, cnt_in;
   logic              dvld_ff, dvld_in;
   logic [31:0]       lo_ff, lo_in;
   logic [31:0]       hi_ff, hi_in;
   wls_rsp_type       rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic [CH_W-1:0]   cur_ch;
   logic [FILL_W-1:0] cur_fill;
   logic [PROD_W-1:0] prod;
   logic [FILL_W-1:0] div100;
   logic [31:0]       mid;
   logic [31:0]       lo_nx, hi_nx;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [ADDR_W-1:0] wr_addr;
   logic              rec_commit;
   logic              clear_all;
   logic              full;
   logic [SUM_W-1:0]  sum_in;
   logic [WIN_W-1:0]  wp_in;
   logic              div_start;
   logic [SUM_W-1:0]  div_quo;
   logic              div_done;

   assign cur_ch   = (state_ff == ST_IDLE) ? cmd.ch[CH_W-1:0] : ch_ff;
   assign cur_fill = fill_ff[cur_ch];
   assign prod     = PROD_W'(cur_fill) * PROD_W'(RECIP100);
   assign div100   = FILL_W'(prod >> RECIP_SH);
   assign mid      = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign full     = fill_ff[ch_ff] == FILL_W'(WINDOW_DEPTH);
   assign wr_addr  = ADDR_W'(ch_ff) * ADDR_W'(WINDOW_DEPTH) + ADDR_W'(wp_ff[ch_ff]);
   assign sum_in   = sum_ff[ch_ff] - (full ? SUM_W'(rd_data_ff) : '0) + SUM_W'(val_ff);
   assign wp_in    = (wp_ff[ch_ff] == WIN_W'(WINDOW_DEPTH - 1)) ? '0 : wp_ff[ch_ff] + 1'b1;

   wls_divider #(
      .DVD_W (SUM_W),
      .DSR_W (FILL_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_ff[cur_ch]),
      .divisor  (cur_fill),
      .quotient (div_quo),
      .done     (div_done)
   );

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      ch_in        = ch_ff;
      val_in       = val_ff;
      n_in         = n_ff;
      rank_in      = rank_ff;
      scan_in      = scan_ff;
      cnt_in       = cnt_ff;
      dvld_in      = 1'b0;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd_pop      = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = ADDR_W'(ch_ff) * ADDR_W'(WINDOW_DEPTH) + ADDR_W'(scan_ff);
      rec_commit   = 1'b0;
      clear_all    = 1'b0;
      div_start    = 1'b0;
      lo_nx        = lo_ff;
      hi_nx        = hi_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               op_in   = cmd.op;
               ch_in   = cur_ch;
               val_in  = cmd.value;
               case (cmd.op)
                  OP_RECORD: begin
                     rd_en    = 1'b1;
                     rd_addr  = ADDR_W'(cur_ch) * ADDR_W'(WINDOW_DEPTH)
                                + ADDR_W'(wp_ff[cur_ch]);
                     state_in = ST_REC_UPD;
                  end
                  OP_QUERY: begin
                     n_in     = cur_fill;
                     rank_in  = cur_fill - div100;
                     scan_in  = '0;
                     cnt_in   = '0;
                     lo_in    = '0;
                     hi_in    = '1;
                     if (cur_fill == '0) begin
                        state_in = ST_RESULT;
                     end else begin
                        div_start = 1'b1;
                        state_in  = ST_Q_SCAN;
                     end
                  end
                  OP_QUERY_ZERO: begin
                     state_in = ST_RESULT;
                  end
                  OP_CLEAR: begin
                     clear_all = 1'b1;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_REC_UPD: begin
            rec_commit = 1'b1;
            state_in   = ST_IDLE;
         end
         ST_Q_SCAN: begin
            // read one window entry a cycle, count those at or below mid
            if (scan_ff != n_ff) begin
               rd_en   = 1'b1;
               dvld_in = 1'b1;
               scan_in = scan_ff + 1'b1;
            end
            if (dvld_ff && rd_data_ff <= mid) begin
               cnt_in = cnt_ff + 1'b1;
            end
            if (scan_ff == n_ff && !dvld_ff) begin
               state_in = ST_Q_DECIDE;
            end
         end
         ST_Q_DECIDE: begin
            if (cnt_ff >= rank_ff) begin
               hi_nx = mid;
            end else begin
               lo_nx = mid + 1'b1;
            end
            lo_in   = lo_nx;
            hi_in   = hi_nx;
            scan_in = '0;
            cnt_in  = '0;
            state_in = (lo_nx == hi_nx) ? ST_Q_WAIT_DIV : ST_Q_SCAN;
         end
         ST_Q_WAIT_DIV: begin
            if (div_done) begin
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '0;
               if (op_ff == OP_QUERY) begin
                  rsp_in.sample_total = 11'(n_ff);
                  if (n_ff != '0) begin
                     rsp_in.min_latency  = min_ff[ch_ff];
                     rsp_in.max_latency  = max_ff[ch_ff];
                     rsp_in.mean_latency = div_quo[31:0];
                     rsp_in.p99_latency  = lo_ff;
                  end
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         dvld_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         dvld_ff      <= dvld_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      ch_ff   <= ch_in;
      val_ff  <= val_in;
      n_ff    <= n_in;
      rank_ff <= rank_in;
      scan_ff <= scan_in;
      cnt_ff  <= cnt_in;
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      rsp_ff  <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset || clear_all) begin
         for (int i = 0; i < CHANNEL_COUNT; i++) begin
            wp_ff[i]   <= '0;
            fill_ff[i] <= '0;
            sum_ff[i]  <= '0;
            min_ff[i]  <= '1;
            max_ff[i]  <= '0;
         end
      end else if (rec_commit) begin
         wp_ff[ch_ff]  <= wp_in;
         sum_ff[ch_ff] <= sum_in;
         if (!full) begin
            fill_ff[ch_ff] <= fill_ff[ch_ff] + 1'b1;
         end
         if (val_ff < min_ff[ch_ff]) begin
            min_ff[ch_ff] <= val_ff;
         end
         if (val_ff > max_ff[ch_ff]) begin
            max_ff[ch_ff] <= val_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
      if (rec_commit) begin
         mem[wr_addr] <= val_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_Q_SCAN) |-> (scan_ff <= n_ff))
      else $error("scan index ran past window fill");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_Q_SCAN || state_ff == ST_Q_DECIDE) |-> (lo_ff <= hi_ff))
      else $error("rank search bounds crossed");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_REC_UPD) |-> ($past(state_ff) == ST_IDLE && $past(cmd_pop)))
      else $error("record update without a popped command");

   assert property (@(posedge clock) disable iff (reset)
      cur_fill <= FILL_W'(WINDOW_DEPTH))
      else $error("fill count above window depth");

endmodule
